// ===== hdl/snp_pair_ld_estimator_macros.svh =====
// Assertion macros shared by the LD estimator modules.
`ifndef SNP_PAIR_LD_ESTIMATOR_MACROS_SVH
`define SNP_PAIR_LD_ESTIMATOR_MACROS_SVH

// Property holds at every clock edge outside reset.
`define SNP_LD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define SNP_LD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SNP_LD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/snp_ld_pkg.sv =====
// Types and constants shared by the LD estimator modules.
`default_nettype none

package snp_ld_pkg;

  localparam int CNT_W  = 12;   // used individual count
  localparam int MAJ_W  = 13;   // major allele counts
  localparam int GAM_W  = 13;   // gamete class counts
  localparam int CMP_W  = 12;   // composite class counts
  localparam int TOT_W  = 12;   // total_individuals register
  localparam int MODE_W = 2;
  localparam int D_W    = 30;
  localparam int R2_W   = 28;
  localparam int SUM_W  = 17;   // weighted composite sum, at most 8n

  localparam int MUL_W  = 28;
  localparam int PROD_W = 2 * MUL_W;
  localparam int T1_W   = 28;
  localparam int T2_W   = 26;
  localparam int NN_W   = 24;
  localparam int VA_W   = 24;
  localparam int V_W    = 48;
  localparam int MAG_W  = 28;
  localparam int ND_W   = 30;

  localparam int D_SHIFT    = 29;
  localparam int R2_SHIFT   = 25;
  localparam int DIV_NUM_W  = PROD_W + R2_SHIFT;
  localparam int DIV_DEN_W  = V_W;
  localparam int DIV_QUO_W  = 34;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);
  localparam int R2_INT_LSB = 29;

  localparam logic [D_SHIFT-1:0] D_LIMIT = 29'h1000_0000;
  localparam logic [R2_W-1:0]    R2_MAX  = 28'hFFF_FFFF;

  localparam logic [1:0]        ALLELE_MAJOR    = 2'd1;
  localparam logic [1:0]        ALLELE_MINOR    = 2'd2;
  localparam logic [MODE_W-1:0] PHASE_COMPOSITE = 2'd2;

  localparam logic REG_PHASE_MODE = 1'b0;
  localparam logic REG_TOTAL      = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_MUL_T1,
    ST_MUL_T2,
    ST_MUL_NN,
    ST_MUL_VA,
    ST_MUL_VB,
    ST_MUL_V,
    ST_MUL_N2,
    ST_DIVD_START,
    ST_DIVD_RUN,
    ST_DIVR_START,
    ST_DIVR_RUN,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_T1,
    MUL_T2,
    MUL_NN,
    MUL_VA,
    MUL_VB,
    MUL_V,
    MUL_N2
  } mul_step_t;

  typedef enum logic {
    DIV_D,
    DIV_R2
  } div_sel_t;

  typedef struct packed {
    logic      take;
    logic      init_res;
    mul_step_t mul_step;
    logic      cap_mag;
    logic      div_start;
    div_sel_t  div_sel;
    logic      cap_d;
    logic      cap_r2;
    logic      load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic v_zero;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/snp_ld_div.sv =====
// Restoring divider, one quotient bit per cycle, with quotient overflow flag.
`default_nettype none

module snp_ld_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [snp_ld_pkg::DIV_NUM_W-1:0] num,
  input  logic [snp_ld_pkg::DIV_DEN_W-1:0] den,
  output logic                             done,
  output logic [snp_ld_pkg::DIV_QUO_W-1:0] quo,
  output logic                             ovf
);
  import snp_ld_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] num_sh;
  logic [DIV_DEN_W-1:0] den_reg;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  assign shifted = {rem, num_sh[DIV_NUM_W-1]};
  assign diff    = shifted - {1'b0, den_reg};
  assign ge      = shifted >= {1'b0, den_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= DIV_CNT_W'(DIV_NUM_W);
    end else if (busy) begin
      cnt <= cnt - DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh  <= num;
      den_reg <= den;
      rem     <= '0;
      quo     <= '0;
      ovf     <= 1'b0;
    end else if (busy) begin
      num_sh <= num_sh << 1;
      rem    <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      quo    <= {quo[DIV_QUO_W-2:0], ge};
      // a bit pushed out the top means the quotient is too large to hold
      ovf    <= ovf | quo[DIV_QUO_W-1];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/snp_ld_ctrl.sv =====
// Sequencer for counting, the shared multiplier and the two divisions.
`default_nettype none
`include "snp_pair_ld_estimator_macros.svh"

module snp_ld_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  logic                   last_individual,
  input  snp_ld_pkg::dp_status_t status,
  output logic                   item_stall,
  output snp_ld_pkg::dp_cmd_t    cmd
);
  import snp_ld_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid && last_individual) state_next = ST_START;
      end
      ST_START: begin
        state_next = status.n_zero ? ST_FINISH : ST_MUL_T1;
      end
      ST_MUL_T1:     state_next = ST_MUL_T2;
      ST_MUL_T2:     state_next = ST_MUL_NN;
      ST_MUL_NN:     state_next = ST_MUL_VA;
      ST_MUL_VA:     state_next = ST_MUL_VB;
      ST_MUL_VB:     state_next = ST_MUL_V;
      ST_MUL_V:      state_next = ST_MUL_N2;
      ST_MUL_N2:     state_next = ST_DIVD_START;
      ST_DIVD_START: state_next = ST_DIVD_RUN;
      ST_DIVD_RUN: begin
        if (status.div_done) state_next = status.v_zero ? ST_FINISH : ST_DIVR_START;
      end
      ST_DIVR_START: state_next = ST_DIVR_RUN;
      ST_DIVR_RUN: begin
        if (status.div_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall   = 1'b1;
    cmd          = '0;
    cmd.mul_step = MUL_NONE;
    cmd.div_sel  = DIV_D;
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        cmd.take   = item_valid;
      end
      ST_START:  cmd.init_res = 1'b1;
      ST_MUL_T1: cmd.mul_step = MUL_T1;
      ST_MUL_T2: cmd.mul_step = MUL_T2;
      ST_MUL_NN: begin
        cmd.mul_step = MUL_NN;
        cmd.cap_mag  = 1'b1;
      end
      ST_MUL_VA: cmd.mul_step = MUL_VA;
      ST_MUL_VB: cmd.mul_step = MUL_VB;
      ST_MUL_V:  cmd.mul_step = MUL_V;
      ST_MUL_N2: cmd.mul_step = MUL_N2;
      ST_DIVD_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_D;
      end
      ST_DIVD_RUN: begin
        cmd.div_sel = DIV_D;
        cmd.cap_d   = status.div_done;
      end
      ST_DIVR_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_R2;
      end
      ST_DIVR_RUN: begin
        cmd.div_sel = DIV_R2;
        cmd.cap_r2  = status.div_done;
      end
      ST_FINISH: cmd.load_out = status.out_free;
      default: begin
        item_stall = 1'b1;
      end
    endcase
  end

  `SNP_LD_ASSERT_NEXT(a_div_restart, clk, rst, cmd.div_start, !status.div_done, "divider done stale after start")
  `SNP_LD_ASSERT_NEXT(a_last_stalls, clk, rst, cmd.take && last_individual, item_stall, "request taken after last item")

endmodule

`default_nettype wire

// ===== hdl/snp_ld_dp.sv =====
// Counters, shared multiplier, divider hookup and result register.
`default_nettype none
`include "snp_pair_ld_estimator_macros.svh"

module snp_ld_dp #(
  parameter int MAX_INDIVIDUALS = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [snp_ld_pkg::TOT_W-1:0]  cfg_data,
  input  logic [1:0]                    locus_a_first,
  input  logic [1:0]                    locus_a_second,
  input  logic [1:0]                    locus_b_first,
  input  logic [1:0]                    locus_b_second,
  input  snp_ld_pkg::dp_cmd_t           cmd,
  output snp_ld_pkg::dp_status_t        status,
  input  logic                          result_stall,
  output logic                          result_valid,
  output logic [snp_ld_pkg::CNT_W-1:0]  used_count,
  output logic                          pair_usable,
  output logic [snp_ld_pkg::MAJ_W-1:0]  major_count_a,
  output logic [snp_ld_pkg::MAJ_W-1:0]  major_count_b,
  output logic signed [snp_ld_pkg::D_W-1:0] d_value,
  output logic [snp_ld_pkg::R2_W-1:0]   r2_value,
  output logic                          r2_saturated,
  output logic                          variance_zero
);
  import snp_ld_pkg::*;

  localparam int CapInt = (MAX_INDIVIDUALS < 4095) ? MAX_INDIVIDUALS : 4095;
  localparam logic [CNT_W-1:0] USED_CAP = CNT_W'(CapInt);

  // configuration
  logic [MODE_W-1:0] phase_mode;
  logic [TOT_W-1:0]  total_individuals;
  logic              mode2;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_mode        <= '0;
      total_individuals <= TOT_W'(2);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PHASE_MODE: phase_mode        <= cfg_data[MODE_W-1:0];
        REG_TOTAL:      total_individuals <= cfg_data;
      endcase
    end
  end

  assign mode2 = phase_mode == PHASE_COMPOSITE;

  // counting
  logic [CNT_W-1:0] used_cnt;
  logic [MAJ_W-1:0] maj_a;
  logic [MAJ_W-1:0] maj_b;
  logic [GAM_W-1:0] gam_cnt [4];
  logic [CMP_W-1:0] cmp_cnt [4];
  logic             item_ok;
  logic             count_en;
  logic [1:0]       gam_idx1;
  logic [1:0]       gam_idx2;
  logic             a_hom;
  logic             b_hom;
  logic             a_het;
  logic             b_het;
  logic             cmp_hit;
  logic [1:0]       cmp_idx;

  assign item_ok = (locus_a_first  == ALLELE_MAJOR || locus_a_first  == ALLELE_MINOR) &&
                   (locus_a_second == ALLELE_MAJOR || locus_a_second == ALLELE_MINOR) &&
                   (locus_b_first  == ALLELE_MAJOR || locus_b_first  == ALLELE_MINOR) &&
                   (locus_b_second == ALLELE_MAJOR || locus_b_second == ALLELE_MINOR);
  assign count_en = cmd.take && item_ok && (used_cnt < USED_CAP);

  assign gam_idx1 = {locus_a_first == ALLELE_MINOR, locus_b_first == ALLELE_MINOR};
  assign gam_idx2 = {locus_a_second == ALLELE_MINOR, locus_b_second == ALLELE_MINOR};

  assign a_hom = (locus_a_first == ALLELE_MAJOR) && (locus_a_second == ALLELE_MAJOR);
  assign b_hom = (locus_b_first == ALLELE_MAJOR) && (locus_b_second == ALLELE_MAJOR);
  assign a_het = locus_a_first != locus_a_second;
  assign b_het = locus_b_first != locus_b_second;

  always_comb begin
    cmp_hit = 1'b1;
    cmp_idx = 2'd0;
    if (a_hom && b_hom) begin
      cmp_idx = 2'd0;
    end else if (a_hom && b_het) begin
      cmp_idx = 2'd1;
    end else if (a_het && b_hom) begin
      cmp_idx = 2'd2;
    end else if (a_het && b_het) begin
      cmp_idx = 2'd3;
    end else begin
      cmp_hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      used_cnt <= '0;
      maj_a    <= '0;
      maj_b    <= '0;
      for (int i = 0; i < 4; i++) begin
        gam_cnt[i] <= '0;
        cmp_cnt[i] <= '0;
      end
    end else if (count_en) begin
      used_cnt <= used_cnt + CNT_W'(1);
      maj_a    <= maj_a + MAJ_W'(locus_a_first == ALLELE_MAJOR)
                        + MAJ_W'(locus_a_second == ALLELE_MAJOR);
      maj_b    <= maj_b + MAJ_W'(locus_b_first == ALLELE_MAJOR)
                        + MAJ_W'(locus_b_second == ALLELE_MAJOR);
      for (int i = 0; i < 4; i++) begin
        gam_cnt[i] <= gam_cnt[i] + GAM_W'(gam_idx1 == 2'(i)) + GAM_W'(gam_idx2 == 2'(i));
        cmp_cnt[i] <= cmp_cnt[i] + CMP_W'(cmp_hit && (cmp_idx == 2'(i)));
      end
    end
  end

  // shared multiplier
  logic [MAJ_W-1:0]  two_n;
  logic [MAJ_W-1:0]  rest_a;
  logic [MAJ_W-1:0]  rest_b;
  logic [SUM_W-1:0]  cmp_sum;
  logic [SUM_W-1:0]  cmp_weight;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;
  logic [T1_W-1:0]   t1;
  logic [T2_W-1:0]   t2;
  logic [NN_W-1:0]   nn;
  logic [VA_W-1:0]   va;
  logic [VA_W-1:0]   vb;
  logic [V_W-1:0]    v;
  logic [PROD_W-1:0] n2;
  logic signed [ND_W-1:0] nd;
  logic        [ND_W-1:0] nd_abs;
  logic        [MAG_W-1:0] mag;
  logic                    nd_neg;

  assign two_n      = {used_cnt, 1'b0};
  assign rest_a     = two_n - maj_a;
  assign rest_b     = two_n - maj_b;
  assign cmp_sum    = (SUM_W'(cmp_cnt[0]) << 1) + SUM_W'(cmp_cnt[1]) + SUM_W'(cmp_cnt[2]);
  // 4 * (2 c0 + c1 + c2) + 2 c3, so that D = nd / (4 n^2)
  assign cmp_weight = (cmp_sum << 2) + (SUM_W'(cmp_cnt[3]) << 1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_step)
      MUL_T1: begin
        mul_a = mode2 ? MUL_W'(used_cnt)   : MUL_W'(gam_cnt[0]);
        mul_b = mode2 ? MUL_W'(cmp_weight) : MUL_W'(gam_cnt[3]);
      end
      MUL_T2: begin
        mul_a = mode2 ? MUL_W'(maj_a) : MUL_W'(gam_cnt[1]);
        mul_b = mode2 ? MUL_W'(maj_b) : MUL_W'(gam_cnt[2]);
      end
      MUL_NN: begin
        mul_a = MUL_W'(used_cnt);
        mul_b = MUL_W'(used_cnt);
      end
      MUL_VA: begin
        mul_a = MUL_W'(maj_a);
        mul_b = MUL_W'(rest_a);
      end
      MUL_VB: begin
        mul_a = MUL_W'(maj_b);
        mul_b = MUL_W'(rest_b);
      end
      MUL_V: begin
        mul_a = MUL_W'(va);
        mul_b = MUL_W'(vb);
      end
      MUL_N2: begin
        mul_a = mag;
        mul_b = mag;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    case (cmd.mul_step)
      MUL_T1:  t1 <= prod[T1_W-1:0];
      MUL_T2:  t2 <= prod[T2_W-1:0];
      MUL_NN:  nn <= prod[NN_W-1:0];
      MUL_VA:  va <= prod[VA_W-1:0];
      MUL_VB:  vb <= prod[VA_W-1:0];
      MUL_V:   v  <= prod[V_W-1:0];
      MUL_N2:  n2 <= prod;
      default: ;
    endcase
  end

  // numerator of D and its magnitude
  assign nd     = $signed({2'b00, t1}) -
                  $signed(mode2 ? {3'b000, t2, 1'b0} : {4'b0000, t2});
  assign nd_abs = nd[ND_W-1] ? ND_W'(-nd) : ND_W'(nd);

  always_ff @(posedge clk) begin
    if (cmd.cap_mag) begin
      nd_neg <= nd[ND_W-1];
      mag    <= nd_abs[MAG_W-1:0];
    end
  end

  // divider
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_QUO_W-1:0] div_quo;
  logic                 div_ovf;

  always_comb begin
    if (cmd.div_sel == DIV_D) begin
      // (|nd| * 2^29 + n^2) / (2 n^2) rounds |nd| / (4 n^2) to Q.30
      div_num = (DIV_NUM_W'(mag) << D_SHIFT) + DIV_NUM_W'(nn);
      div_den = DIV_DEN_W'({nn, 1'b0});
    end else begin
      div_num = {n2, {R2_SHIFT{1'b0}}};
      div_den = v;
    end
  end

  snp_ld_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  // result capture
  logic                   d_big;
  logic [D_SHIFT-1:0]     d_mag;
  logic                   r2_big;
  logic [R2_INT_LSB:0]    r2_round;
  logic signed [D_W-1:0]  d_res;
  logic [R2_W-1:0]        r2_res;
  logic                   sat_res;
  logic                   vz_res;

  assign d_big    = div_ovf || (div_quo > DIV_QUO_W'(D_LIMIT));
  assign d_mag    = d_big ? D_LIMIT : div_quo[D_SHIFT-1:0];
  // quotient holds r2 with one extra fraction bit; saturate at 16 or on round-up
  assign r2_big   = div_ovf || (div_quo[DIV_QUO_W-1:R2_INT_LSB] != '0) ||
                    (div_quo[R2_INT_LSB-1:0] == '1);
  assign r2_round = (R2_INT_LSB+1)'(div_quo[R2_INT_LSB-1:0]) + (R2_INT_LSB+1)'(1);

  always_ff @(posedge clk) begin
    if (cmd.init_res) begin
      d_res   <= '0;
      r2_res  <= '0;
      sat_res <= 1'b0;
      vz_res  <= 1'b1;
    end else begin
      if (cmd.cap_d) begin
        d_res <= nd_neg ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag});
      end
      if (cmd.cap_r2) begin
        r2_res  <= r2_big ? R2_MAX : r2_round[R2_W:1];
        sat_res <= r2_big;
        vz_res  <= 1'b0;
      end
    end
  end

  // output register
  logic out_free;

  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      used_count    <= used_cnt;
      pair_usable   <= used_cnt > (total_individuals >> 1);
      major_count_a <= maj_a;
      major_count_b <= maj_b;
      d_value       <= d_res;
      r2_value      <= r2_res;
      r2_saturated  <= sat_res;
      variance_zero <= vz_res;
    end
  end

  assign status.n_zero   = used_cnt == '0;
  assign status.v_zero   = v == '0;
  assign status.div_done = div_done;
  assign status.out_free = out_free;

  `SNP_LD_ASSERT(a_used_cap, clk, rst, used_cnt <= USED_CAP, "used count above capacity")
  `SNP_LD_ASSERT(a_major_a, clk, rst, maj_a <= two_n, "major count A above two per individual")
  `SNP_LD_ASSERT(a_gamete_sum, clk, rst, (15'(gam_cnt[0]) + 15'(gam_cnt[1]) + 15'(gam_cnt[2]) + 15'(gam_cnt[3])) == (15'(used_cnt) << 1), "gamete classes do not add to 2n")

endmodule

`default_nettype wire

// ===== hdl/snp_pair_ld_estimator.sv =====
// Pairwise LD estimator for two SNP loci: D and r2 from streamed genotypes.
//
// Input channel (item_valid / item_stall): one individual per request, four
// allele codes (0 missing, 1 major, 2 minor) and last_individual. Requests
// are taken one per cycle while the block counts. An individual with any
// missing or invalid allele is skipped.
// A request marked last closes the locus pair: item_stall rises and the
// block works out D and r2 with one shared 28x28 multiplier and a restoring
// divider that retires one quotient bit per cycle (81 steps per division).
// Result channel (result_valid / result_stall): one result per pair, held in
// an output register. The r2 division is skipped when either variance
// vanishes, and both divisions are skipped when no individual was used.
// The counters clear as the result is loaded, so the next pair streams in
// while the result waits; after a last request the block stalls its input
// until the register frees. A stalled result holds its value.
// Configuration (cfg_write, cfg_index, cfg_data): index 0 phase_mode,
// index 1 total_individuals, written while no pair is in flight.
// Reset (rst, synchronous): counters clear, phase_mode 0, total 2.
`default_nettype none

module snp_pair_ld_estimator #(
  parameter int MAX_INDIVIDUALS = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [snp_ld_pkg::TOT_W-1:0]      cfg_data,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [1:0]                        locus_a_first,
  input  logic [1:0]                        locus_a_second,
  input  logic [1:0]                        locus_b_first,
  input  logic [1:0]                        locus_b_second,
  input  logic                              last_individual,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [snp_ld_pkg::CNT_W-1:0]      used_count,
  output logic                              pair_usable,
  output logic [snp_ld_pkg::MAJ_W-1:0]      major_count_a,
  output logic [snp_ld_pkg::MAJ_W-1:0]      major_count_b,
  output logic signed [snp_ld_pkg::D_W-1:0] d_value,
  output logic [snp_ld_pkg::R2_W-1:0]       r2_value,
  output logic                              r2_saturated,
  output logic                              variance_zero
);
  import snp_ld_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  snp_ld_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .last_individual (last_individual),
    .status          (status),
    .item_stall      (item_stall),
    .cmd             (cmd)
  );

  snp_ld_dp #(
    .MAX_INDIVIDUALS (MAX_INDIVIDUALS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .locus_a_first  (locus_a_first),
    .locus_a_second (locus_a_second),
    .locus_b_first  (locus_b_first),
    .locus_b_second (locus_b_second),
    .cmd            (cmd),
    .status         (status),
    .result_stall   (result_stall),
    .result_valid   (result_valid),
    .used_count     (used_count),
    .pair_usable    (pair_usable),
    .major_count_a  (major_count_a),
    .major_count_b  (major_count_b),
    .d_value        (d_value),
    .r2_value       (r2_value),
    .r2_saturated   (r2_saturated),
    .variance_zero  (variance_zero)
  );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for snp_pair_ld_estimator: random genotype streams checked against a tally predictor.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import snp_ld_pkg::*;

  localparam int MAX_IND        = 2048;
  localparam int USED_CAP       = (MAX_IND < 4095) ? MAX_IND : 4095;
  localparam int RESULT_LATENCY = 200;
  localparam int HOLD_CYCLES    = 900;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int REPORT_MAX     = 10;
  localparam int BLOCK_ITEMS    = 30;

  localparam logic [1:0] ALLELE_MISSING = 2'd0;
  localparam logic [1:0] ALLELE_INVALID = 2'd3;

  localparam logic [MODE_W-1:0] PHASE_GAMETE       = 2'd0;
  localparam logic [MODE_W-1:0] PHASE_GAMETE_ALT   = 2'd1;
  localparam logic [MODE_W-1:0] PHASE_GAMETE_SPARE = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] used;
    logic             usable;
    logic [MAJ_W-1:0] maj_a;
    logic [MAJ_W-1:0] maj_b;
    logic [D_W-1:0]   d;
    logic [R2_W-1:0]  r2;
    logic             sat;
    logic             vz;
  } pair_result_t;

  class ld_tally_checker;
    logic [MODE_W-1:0] mode = PHASE_GAMETE;
    logic [TOT_W-1:0]  total = 2;
    int unsigned       used_n, major_a, major_b;
    int unsigned       gam[4];
    int unsigned       comp[4];
    pair_result_t      expected_pairs[$];
    int                faults;
    int                pairs_checked;

    function void set_register(logic idx, logic [TOT_W-1:0] data);
      if (idx == REG_PHASE_MODE) mode = data[MODE_W-1:0];
      else total = data;
    endfunction

    function int pending();
      return expected_pairs.size();
    endfunction

    // D and r2 of the pair from the current tallies
    function pair_result_t predict_pair();
      pair_result_t    res;
      longint unsigned n, ma, mb, mag, nn, q, v, sq, q0, rem, frac, r2;
      longint          nd, dq;
      bit              sat, vz;
      int              i;
      n = used_n;
      ma = major_a;
      mb = major_b;
      nd = 0;
      dq = 0;
      r2 = 0;
      sat = 0;
      vz = 1;
      if (n != 0) begin
        if (mode == PHASE_COMPOSITE) begin
          nd = 4 * longint'(n) * (2 * longint'(comp[0]) + longint'(comp[1]) + longint'(comp[2]))
               + 2 * longint'(n) * longint'(comp[3]) - 2 * longint'(ma * mb);
        end else begin
          nd = longint'(gam[0]) * longint'(gam[3]) - longint'(gam[1]) * longint'(gam[2]);
        end
        mag = (nd < 0) ? -nd : nd;
        nn = n * n;
        // D = nd / (4 n^2) in Q.30, rounded half away from zero
        q = ((mag << D_SHIFT) + nn) / (2 * nn);
        if (q > D_LIMIT) q = D_LIMIT;
        dq = (nd < 0) ? -longint'(q) : longint'(q);
        v = ma * (2 * n - ma) * mb * (2 * n - mb);
        if (v != 0) begin
          vz = 0;
          sq = mag * mag;
          q0 = sq / v;
          rem = sq % v;
          if (q0 >= 16) begin
            sat = 1;
            r2 = R2_MAX;
          end else begin
            frac = 0;
            for (i = 0; i < 25; i++) begin
              rem = rem << 1;
              frac = frac << 1;
              if (rem >= v) begin
                rem = rem - v;
                frac = frac | 1;
              end
            end
            r2 = (q0 << 24) + (frac >> 1) + (frac & 1);
            if (r2 > R2_MAX) begin
              sat = 1;
              r2 = R2_MAX;
            end
          end
        end
      end
      res.used   = n[CNT_W-1:0];
      res.usable = (n > (total / 2));
      res.maj_a  = ma[MAJ_W-1:0];
      res.maj_b  = mb[MAJ_W-1:0];
      res.d      = dq[D_W-1:0];
      res.r2     = r2[R2_W-1:0];
      res.sat    = sat;
      res.vz     = vz;
      return res;
    endfunction

    function void take_individual(logic [1:0] a1, logic [1:0] a2, logic [1:0] b1,
                                  logic [1:0] b2, logic last);
      bit ok, ahm, bhm, ahe, bhe;
      int k;
      ok = (a1 == ALLELE_MAJOR || a1 == ALLELE_MINOR) && (a2 == ALLELE_MAJOR || a2 == ALLELE_MINOR)
           && (b1 == ALLELE_MAJOR || b1 == ALLELE_MINOR)
           && (b2 == ALLELE_MAJOR || b2 == ALLELE_MINOR);
      if (ok && used_n < USED_CAP) begin
        ahm = (a1 == ALLELE_MAJOR) && (a2 == ALLELE_MAJOR);
        bhm = (b1 == ALLELE_MAJOR) && (b2 == ALLELE_MAJOR);
        ahe = (a1 != a2);
        bhe = (b1 != b2);
        used_n++;
        major_a += (a1 == ALLELE_MAJOR) + (a2 == ALLELE_MAJOR);
        major_b += (b1 == ALLELE_MAJOR) + (b2 == ALLELE_MAJOR);
        gam[{a1 == ALLELE_MINOR, b1 == ALLELE_MINOR}]++;
        gam[{a2 == ALLELE_MINOR, b2 == ALLELE_MINOR}]++;
        if (ahm && bhm) comp[0]++;
        else if (ahm && bhe) comp[1]++;
        else if (ahe && bhm) comp[2]++;
        else if (ahe && bhe) comp[3]++;
      end
      if (last) begin
        expected_pairs.push_back(predict_pair());
        used_n = 0;
        major_a = 0;
        major_b = 0;
        for (k = 0; k < 4; k++) begin
          gam[k] = 0;
          comp[k] = 0;
        end
      end
    endfunction

    function void compare_field(string field, longint want, longint got);
      if (want != got) begin
        faults++;
        if (faults <= REPORT_MAX)
          $display("pair %0d: %s expected %0d, got %0d", pairs_checked, field, want, got);
      end
    endfunction

    function void check_pair_result(pair_result_t got);
      pair_result_t want;
      if (expected_pairs.size() == 0) begin
        faults++;
        if (faults <= REPORT_MAX)
          $display("result with no pair pending: used_count %0d d_value %0d",
                   got.used, $signed(got.d));
        return;
      end
      want = expected_pairs.pop_front();
      compare_field("used_count", want.used, got.used);
      compare_field("pair_usable", want.usable, got.usable);
      compare_field("major_count_a", want.maj_a, got.maj_a);
      compare_field("major_count_b", want.maj_b, got.maj_b);
      compare_field("d_value", longint'($signed(want.d)), longint'($signed(got.d)));
      compare_field("r2_value", want.r2, got.r2);
      compare_field("r2_saturated", want.sat, got.sat);
      compare_field("variance_zero", want.vz, got.vz);
      pairs_checked++;
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     cfg_write;
  logic                     cfg_index;
  logic [TOT_W-1:0]         cfg_data;
  logic                     item_valid;
  logic                     item_stall;
  logic [1:0]               locus_a_first;
  logic [1:0]               locus_a_second;
  logic [1:0]               locus_b_first;
  logic [1:0]               locus_b_second;
  logic                     last_individual;
  logic                     result_valid;
  logic                     result_stall;
  logic [CNT_W-1:0]         used_count;
  logic                     pair_usable;
  logic [MAJ_W-1:0]         major_count_a;
  logic [MAJ_W-1:0]         major_count_b;
  logic signed [D_W-1:0]    d_value;
  logic [R2_W-1:0]          r2_value;
  logic                     r2_saturated;
  logic                     variance_zero;

  ld_tally_checker tally = new();
  pair_result_t    seen;
  int              tx_idle_pct = 0;
  int              rx_idle_pct = 0;
  int              items_sent = 0;
  int              backpressure_cycles = 0;
  int              cycles = 0;
  int              hold_left = 0;
  int              holds_asked = 0;
  int              holds_started = 0;

  snp_pair_ld_estimator #(
    .MAX_INDIVIDUALS(MAX_IND)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .locus_a_first  (locus_a_first),
    .locus_a_second (locus_a_second),
    .locus_b_first  (locus_b_first),
    .locus_b_second (locus_b_second),
    .last_individual(last_individual),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .used_count     (used_count),
    .pair_usable    (pair_usable),
    .major_count_a  (major_count_a),
    .major_count_b  (major_count_b),
    .d_value        (d_value),
    .r2_value       (r2_value),
    .r2_saturated   (r2_saturated),
    .variance_zero  (variance_zero)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run stopped by watchdog after %0d cycles", cycles);
      $display("[snp_pair_ld_estimator] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_stall) backpressure_cycles++;
      if (item_valid && !item_stall)
        tally.take_individual(locus_a_first, locus_a_second, locus_b_first, locus_b_second,
                              last_individual);
      if (result_valid && !result_stall) begin
        seen.used   = used_count;
        seen.usable = pair_usable;
        seen.maj_a  = major_count_a;
        seen.maj_b  = major_count_b;
        seen.d      = d_value;
        seen.r2     = r2_value;
        seen.sat    = r2_saturated;
        seen.vz     = variance_zero;
        tally.check_pair_result(seen);
      end
    end
  end

  // long receiver hold-off, started on request from the stimulus
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_started != holds_asked) begin
      hold_left <= HOLD_CYCLES;
      holds_started <= holds_started + 1;
    end
  end

  always @(negedge clk) begin
    result_stall <= (hold_left != 0) || ($urandom_range(99) < rx_idle_pct);
  end

  function automatic logic [1:0] draw_allele(int minor_pct);
    return ($urandom_range(99) < minor_pct) ? ALLELE_MINOR : ALLELE_MAJOR;
  endfunction

  function automatic logic [1:0] swap_allele(logic [1:0] a);
    return (a == ALLELE_MAJOR) ? ALLELE_MINOR : ALLELE_MAJOR;
  endfunction

  // occasionally replace a code with a random one, possibly missing or invalid
  function automatic logic [1:0] spoil(logic [1:0] a);
    logic [1:0] code;
    code = 2'($urandom_range(0, 3));
    return ($urandom_range(99) < 5) ? code : a;
  endfunction

  function automatic int pick_minor_pct();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 100;
      2:       return 10;
      3:       return 90;
      default: return 50;
    endcase
  endfunction

  task automatic send_individual(input logic [1:0] a1, input logic [1:0] a2,
                                 input logic [1:0] b1, input logic [1:0] b2, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    item_valid      <= 1'b1;
    locus_a_first   <= a1;
    locus_a_second  <= a2;
    locus_b_first   <= b1;
    locus_b_second  <= b2;
    last_individual <= last;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [TOT_W-1:0] data);
    @(negedge clk);
    item_valid <= 1'b0;
    cfg_write  <= 1'b1;
    cfg_index  <= idx;
    cfg_data   <= data;
    @(negedge clk);
    cfg_write  <= 1'b0;
    tally.set_register(idx, data);
  endtask

  // drop valid, wait for every pending pair, then let the datapath go quiet
  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (tally.pending() != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(posedge clk);
  endtask

  task automatic send_random_pair(input int max_len);
    int         len, minor_a, minor_b, link, k;
    bit         noisy;
    logic       last;
    logic [1:0] a1, a2, b1, b2;
    len = $urandom_range(1, max_len);
    minor_a = pick_minor_pct();
    minor_b = pick_minor_pct();
    link = $urandom_range(0, 3);
    noisy = ($urandom_range(99) < 8);
    for (k = 0; k < len; k++) begin
      a1 = draw_allele(minor_a);
      a2 = draw_allele(minor_a);
      case (link)
        0: begin
          b1 = draw_allele(minor_b);
          b2 = draw_allele(minor_b);
        end
        1: begin
          b1 = a1;
          b2 = a2;
        end
        2: begin
          b1 = swap_allele(a1);
          b2 = swap_allele(a2);
        end
        default: begin
          b1 = ($urandom_range(9) == 0) ? draw_allele(minor_b) : a1;
          b2 = ($urandom_range(9) == 0) ? draw_allele(minor_b) : a2;
        end
      endcase
      last = (k == len - 1);
      if (noisy) begin
        a1 = 2'($urandom_range(0, 3));
        a2 = 2'($urandom_range(0, 3));
        b1 = 2'($urandom_range(0, 3));
        b2 = 2'($urandom_range(0, 3));
        last = last || ($urandom_range(3) == 0);
      end
      send_individual(spoil(a1), spoil(a2), spoil(b1), spoil(b2), last);
    end
  endtask

  task automatic run_block(input int block_no);
    logic [MODE_W-1:0] mode;
    logic [9:0]        junk;
    logic [TOT_W-1:0]  total;
    int                start;
    case (block_no % 4)
      0:       mode = PHASE_GAMETE;
      1:       mode = PHASE_COMPOSITE;
      2:       mode = PHASE_GAMETE_ALT;
      default: mode = PHASE_GAMETE_SPARE;
    endcase
    case ($urandom_range(0, 5))
      0:       total = 2;
      1:       total = 0;
      2:       total = 4095;
      3:       total = 2048;
      default: total = TOT_W'($urandom_range(1, 24));
    endcase
    junk = 10'($urandom);
    write_reg(REG_PHASE_MODE, {junk, mode});
    write_reg(REG_TOTAL, total);
    start = items_sent;
    while (items_sent - start < BLOCK_ITEMS)
      send_random_pair(($urandom_range(9) == 0) ? 40 : 8);
    settle();
  endtask

  initial begin
    int         b, k;
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = REG_PHASE_MODE;
    cfg_data        = '0;
    item_valid      = 1'b0;
    locus_a_first   = ALLELE_MISSING;
    locus_a_second  = ALLELE_MISSING;
    locus_b_first   = ALLELE_MISSING;
    locus_b_second  = ALLELE_MISSING;
    last_individual = 1'b0;
    result_stall    = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: gamete D with a missing or invalid code in every position
    write_reg(REG_PHASE_MODE, TOT_W'(PHASE_GAMETE));
    write_reg(REG_TOTAL, 2);
    send_individual(ALLELE_MAJOR, ALLELE_MAJOR, ALLELE_MAJOR, ALLELE_MAJOR, 1'b0);
    send_individual(ALLELE_MINOR, ALLELE_MINOR, ALLELE_MINOR, ALLELE_MINOR, 1'b0);
    send_individual(ALLELE_MAJOR, ALLELE_MINOR, ALLELE_MINOR, ALLELE_MAJOR, 1'b0);
    send_individual(ALLELE_MINOR, ALLELE_MAJOR, ALLELE_MAJOR, ALLELE_MINOR, 1'b0);
    send_individual(ALLELE_MISSING, ALLELE_MAJOR, ALLELE_MAJOR, ALLELE_MAJOR, 1'b0);
    send_individual(ALLELE_MAJOR, ALLELE_INVALID, ALLELE_MAJOR, ALLELE_MAJOR, 1'b0);
    send_individual(ALLELE_MAJOR, ALLELE_MAJOR, ALLELE_MISSING, ALLELE_MAJOR, 1'b0);
    send_individual(ALLELE_MINOR, ALLELE_MINOR, ALLELE_MINOR, ALLELE_INVALID, 1'b1);
    // nobody used
    send_individual(ALLELE_MISSING, ALLELE_INVALID, ALLELE_INVALID, ALLELE_MISSING, 1'b1);
    // locus A monomorphic
    send_individual(ALLELE_MAJOR, ALLELE_MAJOR, ALLELE_MAJOR, ALLELE_MINOR, 1'b0);
    send_individual(ALLELE_MAJOR, ALLELE_MAJOR, ALLELE_MINOR, ALLELE_MINOR, 1'b1);
    // single used individual
    send_individual(ALLELE_MINOR, ALLELE_MINOR, ALLELE_MINOR, ALLELE_MINOR, 1'b1);
    settle();

    // directed: composite D, clamp at one quarter, every composite class, negative D
    write_reg(REG_PHASE_MODE, TOT_W'(PHASE_COMPOSITE));
    write_reg(REG_TOTAL, 4095);
    send_individual(ALLELE_MAJOR, ALLELE_MAJOR, ALLELE_MAJOR, ALLELE_MAJOR, 1'b0);
    send_individual(ALLELE_MINOR, ALLELE_MINOR, ALLELE_MINOR, ALLELE_MINOR, 1'b1);
    send_individual(ALLELE_MAJOR, ALLELE_MAJOR, ALLELE_MAJOR, ALLELE_MAJOR, 1'b0);
    send_individual(ALLELE_MAJOR, ALLELE_MAJOR, ALLELE_MAJOR, ALLELE_MINOR, 1'b0);
    send_individual(ALLELE_MAJOR, ALLELE_MINOR, ALLELE_MAJOR, ALLELE_MAJOR, 1'b0);
    send_individual(ALLELE_MINOR, ALLELE_MAJOR, ALLELE_MAJOR, ALLELE_MINOR, 1'b0);
    send_individual(ALLELE_MINOR, ALLELE_MINOR, ALLELE_MAJOR, ALLELE_MINOR, 1'b1);
    send_individual(ALLELE_MAJOR, ALLELE_MAJOR, ALLELE_MINOR, ALLELE_MINOR, 1'b0);
    send_individual(ALLELE_MINOR, ALLELE_MINOR, ALLELE_MAJOR, ALLELE_MAJOR, 1'b1);
    settle();

    tx_idle_pct = 7;
    rx_idle_pct = 60;
    for (b = 0; b < 4; b++) run_block(b);
    tx_idle_pct = 60;
    rx_idle_pct = 7;
    for (b = 4; b < 8; b++) run_block(b);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (b = 8; b < 12; b++) run_block(b);

    // hold the result side off while short pairs keep coming, so the input backs up
    write_reg(REG_PHASE_MODE, TOT_W'(PHASE_COMPOSITE));
    write_reg(REG_TOTAL, 3);
    @(negedge clk);
    item_valid <= 1'b0;
    holds_asked <= holds_asked + 1;
    for (k = 0; k < 12; k++) send_random_pair(3);
    settle();

    $display("covered %0d individuals in %0d locus pairs over phase modes 0-3 and totals 0-4095",
             items_sent, tally.pairs_checked);
    $display("input back-pressure for %0d cycles, part of it under one long result hold-off",
             backpressure_cycles);
    if (tally.faults == 0 && tally.pending() == 0) begin
      $display("[snp_pair_ld_estimator] OK");
    end else begin
      $display("mismatches: %0d, pairs still pending: %0d", tally.faults, tally.pending());
      $display("[snp_pair_ld_estimator] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/snp_ld_pkg.sv
hdl/snp_ld_div.sv
hdl/snp_ld_ctrl.sv
hdl/snp_ld_dp.sv
hdl/snp_pair_ld_estimator.sv
test/testbench.sv
